// ===== rtl/w2u_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2u_pkg: shared types and tables of the Windows-1252 to UTF-8 encoder
// Holds the character record passed from the front end to the back end and
// the code point table of the 0x80 to 0x9F range.
// ----------------------------------------------------------------------------
package w2u_pkg;

  localparam int unsigned W2U_BYTE_W      = 8;
  localparam int unsigned W2U_CP_W        = 16;
  localparam int unsigned W2U_QUEUE_DEPTH = 4;

  typedef logic [W2U_BYTE_W-1:0] byte_t;
  typedef logic [W2U_CP_W-1:0]   cp_t;

  // Index of the final UTF-8 byte of a character (count of bytes minus one).
  typedef logic [1:0] last_idx_t;
  localparam last_idx_t LAST_IDX_ONE   = 2'd0;
  localparam last_idx_t LAST_IDX_TWO   = 2'd1;
  localparam last_idx_t LAST_IDX_THREE = 2'd2;

  localparam cp_t   CP_REPLACEMENT = 16'hFFFD;
  localparam cp_t   CP_UNDEFINED   = 16'h0000;
  localparam cp_t   CP_TWO_BYTE_LIM = 16'h0800;
  localparam byte_t LEAD_TWO       = 8'hC0;
  localparam byte_t LEAD_THREE     = 8'hE0;
  localparam byte_t CONT_MARK      = 8'h80;

  // One encoded character, up to three UTF-8 bytes.
  typedef struct packed {
    byte_t [2:0] bytes;
    last_idx_t   last_idx;
    logic        eot;
    logic        subst;
  } w2u_char_t;

  // Code points of bytes 0x80 to 0x9F; zero marks an undefined position.
  function automatic cp_t cp1252_high(input logic [4:0] idx);
    cp_t cp;
    case (idx)
      5'h00: cp = 16'h20AC;
      5'h01: cp = CP_UNDEFINED;
      5'h02: cp = 16'h201A;
      5'h03: cp = 16'h0192;
      5'h04: cp = 16'h201E;
      5'h05: cp = 16'h2026;
      5'h06: cp = 16'h2020;
      5'h07: cp = 16'h2021;
      5'h08: cp = 16'h02C6;
      5'h09: cp = 16'h2030;
      5'h0A: cp = 16'h0160;
      5'h0B: cp = 16'h2039;
      5'h0C: cp = 16'h0152;
      5'h0D: cp = CP_UNDEFINED;
      5'h0E: cp = 16'h017D;
      5'h0F: cp = CP_UNDEFINED;
      5'h10: cp = CP_UNDEFINED;
      5'h11: cp = 16'h2018;
      5'h12: cp = 16'h2019;
      5'h13: cp = 16'h201C;
      5'h14: cp = 16'h201D;
      5'h15: cp = 16'h2022;
      5'h16: cp = 16'h2013;
      5'h17: cp = 16'h2014;
      5'h18: cp = 16'h02DC;
      5'h19: cp = 16'h2122;
      5'h1A: cp = 16'h0161;
      5'h1B: cp = 16'h203A;
      5'h1C: cp = 16'h0153;
      5'h1D: cp = CP_UNDEFINED;
      5'h1E: cp = 16'h017E;
      5'h1F: cp = 16'h0178;
      default: cp = CP_UNDEFINED;
    endcase
    return cp;
  endfunction

endpackage

// ===== rtl/w2u_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2u_if: valid/ready channels of the Windows-1252 to UTF-8 encoder
// Input channel carries one Windows-1252 byte, output channel one UTF-8 byte.
// ----------------------------------------------------------------------------
interface w2u_in_if import w2u_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface w2u_out_if import w2u_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  char_done;
  logic  text_done;
  logic  substituted;

  modport source (output valid, output out_byte, output char_done, output text_done,
                  output substituted, input ready);
  modport sink   (input valid, input out_byte, input char_done, input text_done,
                  input substituted, output ready);
endinterface

// ===== rtl/w2u_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2u_front: input classification and encoding
// Accepts a byte, classifies it by range and builds its UTF-8 character record.
// ----------------------------------------------------------------------------
module w2u_front import w2u_pkg::*; (
  w2u_in_if.sink    in_i,
  input  logic      full_i,
  output logic      push_o,
  output w2u_char_t rec_o
);

  cp_t  cp;
  logic subst;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cp    = {{(W2U_CP_W-W2U_BYTE_W){1'b0}}, in_i.in_byte};
    subst = 1'b0;
    if (in_i.in_byte[7:5] == 3'b100) begin
      cp = cp1252_high(in_i.in_byte[4:0]);
      if (cp == CP_UNDEFINED) begin
        cp    = CP_REPLACEMENT;
        subst = 1'b1;
      end
    end
  end

  always_comb begin
    rec_o.eot   = in_i.end_of_text;
    rec_o.subst = subst;
    rec_o.bytes = '0;
    if (!in_i.in_byte[7]) begin
      rec_o.bytes[0] = in_i.in_byte;
      rec_o.last_idx = LAST_IDX_ONE;
    end else if (cp < CP_TWO_BYTE_LIM) begin
      rec_o.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
      rec_o.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      rec_o.last_idx = LAST_IDX_TWO;
    end else begin
      rec_o.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
      rec_o.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      rec_o.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      rec_o.last_idx = LAST_IDX_THREE;
    end
  end

endmodule

// ===== rtl/w2u_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2u_queue: character queue between front end and back end
// A small register FIFO of encoded characters with a head read port.
// ----------------------------------------------------------------------------
module w2u_queue import w2u_pkg::*; #(
  parameter int unsigned Depth = W2U_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  w2u_char_t wr_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      rd_valid_o,
  output w2u_char_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  w2u_char_t       entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntFull);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> rd_valid_o)
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a word");
`endif

endmodule

// ===== rtl/w2u_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2u_back: byte serializer and output register
// Walks the bytes of the character at the queue head into the output register.
// ----------------------------------------------------------------------------
module w2u_back import w2u_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  w2u_char_t head_i,
  output logic      pop_o,
  w2u_out_if.source out_o
);

  last_idx_t idx_q, idx_d;
  logic      out_valid_q, out_valid_d;
  byte_t     out_byte_q;
  logic      char_done_q, text_done_q, subst_q;
  logic      load;
  logic      is_last;

  // A new word enters the output register when it is empty or being taken.
  assign load    = head_valid_i && (!out_valid_q || out_o.ready);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? LAST_IDX_ONE : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= LAST_IDX_ONE;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= head_i.bytes[idx_q];
      char_done_q <= is_last;
      text_done_q <= is_last && head_i.eot;
      subst_q     <= head_i.subst;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.char_done   = char_done_q;
  assign out_o.text_done   = text_done_q;
  assign out_o.substituted = subst_q;

`ifndef SYNTHESIS
  a_partial_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != LAST_IDX_ONE) |-> head_valid_i)
    else $error("character left the queue before all bytes were sent");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q <= head_i.last_idx))
    else $error("byte index beyond end of character");
  a_text_on_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && text_done_q) |-> char_done_q)
    else $error("end of text flagged on a non-final byte");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && char_done_q))
    else $error("character popped without its final byte");
`endif

endmodule

// ===== rtl/windows1252_to_utf8_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windows1252_to_utf8_encoder_core: Windows-1252 to UTF-8 encoder
// Converts each Windows-1252 byte into one to three UTF-8 bytes.
// ----------------------------------------------------------------------------
//   Channel  Dir  Word                                          Handshake
//   in_i     in   in_byte[7:0], end_of_text                     valid/ready
//   out_o    out  out_byte[7:0], char_done, text_done,          valid/ready
//                 substituted
//
// An input byte is taken in the cycle it arrives while the character queue
// has room; its first output word passes through the queue and then the
// output register. While out_o is ready the output sends one word per cycle,
// so ASCII runs at one byte per cycle and a character of two or three UTF-8
// bytes holds the output while it sends each byte, which the queue absorbs
// until it fills and drops in_i.ready. Reset empties the queue and the output
// register. A stall on out_o backs up into the queue and, once full, to in_i.
module windows1252_to_utf8_encoder_core import w2u_pkg::*; #(
  parameter int unsigned QueueDepth = W2U_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  w2u_in_if.sink     in_i,
  w2u_out_if.source  out_o
);

  logic      push, full, pop, head_valid;
  w2u_char_t wr_rec, head_rec;

  w2u_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (wr_rec)
  );

  w2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_data_i  (wr_rec),
    .full_o     (full),
    .pop_i      (pop),
    .rd_valid_o (head_valid),
    .rd_data_o  (head_rec)
  );

  w2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_rec),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
